/* src/fdn_pkg.sv */
// shared constants, configuration codes and sine generator of the fdn reverb tank
`default_nettype none

package fdn_pkg;

    // default values of the top level parameters
    localparam int LINES_DEF           = 5;
    localparam int MAX_DELAY_DEF       = 4096;
    localparam int MAX_MOD_DELTA_DEF   = 8;
    localparam int SINE_TABLE_SIZE_DEF = 256;
    localparam int SAMPLE_WIDTH_DEF    = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LOWPASS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_LOWPASS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_STEP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_COEFF  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTHS  = 3'd7;

    // register reset values
    localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd45875;
    localparam logic [15:0] DAMPING_COEFF_RST = 16'd32768;
    localparam logic [15:0] LOOP_LOWPASS_RST  = 16'd6554;
    localparam logic [15:0] POST_LOWPASS_RST  = 16'd6554;
    localparam logic [15:0] MOD_DEPTH_RST     = 16'd0;
    localparam logic [23:0] MOD_STEP_RST      = 24'd0;
    localparam logic [15:0] SMOOTH_COEFF_RST  = 16'd62259;
    localparam logic [CFG_DATA_W-1:0] LINE_LENGTHS_RST = 60'd493535678103016541;

    // fixed formats
    localparam int COEF_W      = 16;
    localparam int PHASE_W     = 24;
    localparam int SINE_W      = 24;
    localparam int ST_W        = 28;
    localparam int LEN_FIELD_W = 12;
    localparam int LEN_FIELDS  = 5;
    localparam int IN_SCALE    = 13107;
    localparam int OUT_SCALE   = 26214;
    localparam longint ST_MAX  = 64'sd134217727;

    // sine at a 24-bit phase, quadrant folded odd polynomial in Q22
    function automatic logic signed [SINE_W-1:0] sine_at(input longint q);
        longint quad;
        longint t;
        longint t2;
        longint p;
        longint v;
        quad = (q >> 22) & 64'sd3;
        t    = q & 64'sh3FFFFF;
        if ((quad & 64'sd1) != 0)
        begin
            t = 64'sh400000 - t;
        end
        t2 = (t * t) >> 22;
        p  = 64'sd2699019 - ((t2 * 64'sd304926) >> 22);
        p  = 64'sd6588397 - ((t2 * p) >> 22);
        v  = ((t * p) >> 22) << 1;
        if (v > 64'sd8388607)
        begin
            v = 64'sd8388607;
        end
        if (quad >= 64'sd2)
        begin
            v = -v;
        end
        return SINE_W'(v);
    endfunction

endpackage

`default_nettype wire

/* src/fdn_reverb_tank.sv */
// feedback delay network reverb tank: sequencer, line state and delay memory
`default_nettype none

// One stereo pair in, one stereo pair out. A new pair is taken only while the sequencer
// is idle; a finished result waits in S_DONE while the one before it is still not taken.
// Every line passes through the sequencer twice: once to read and interpolate, once to
// filter and write back. B = clog2(MAX_MOD_DELTA+1) sets the steps of the read position
// wrap, and with modulation on the read pass adds the LFO steps. After reset the delay
// memory is swept to zero over all LINES*MAX_DELAY entries, one entry a cycle; no item
// is taken in that time, configuration writes are. cfg_ready is always high. The user
// must write configuration only while the block is idle; the block does not enforce it.
module fdn_reverb_tank #(
    parameter int LINES           = fdn_pkg::LINES_DEF,
    parameter int MAX_DELAY       = fdn_pkg::MAX_DELAY_DEF,
    parameter int MAX_MOD_DELTA   = fdn_pkg::MAX_MOD_DELTA_DEF,
    parameter int SINE_TABLE_SIZE = fdn_pkg::SINE_TABLE_SIZE_DEF,
    parameter int SAMPLE_WIDTH    = fdn_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fdn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [fdn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      in_left,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      in_right,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]           out_left,
    output logic signed [SAMPLE_WIDTH-1:0]           out_right
);
    import fdn_pkg::*;

    localparam int SW        = SAMPLE_WIDTH;
    localparam int LEN_W     = $clog2(MAX_DELAY + 1);
    localparam int IDX_W     = $clog2(MAX_DELAY);
    localparam int LINE_W    = $clog2(LINES);
    localparam int MEM_DEPTH = LINES * MAX_DELAY;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SIN_W     = $clog2(SINE_TABLE_SIZE);
    localparam int PH_MUL_W  = PHASE_W + SIN_W + 1;
    localparam int RED_B     = $clog2(MAX_MOD_DELTA + 1);
    localparam int RED_W     = $clog2(RED_B + 1);
    localparam int M_W       = $clog2(MAX_MOD_DELTA + 1) + 18;
    localparam int POS_W     = LEN_W + M_W;
    localparam int V_W       = LEN_W + RED_B + 2;
    localparam int TOT_W     = SW + 4;
    localparam int HH_W      = TOT_W + 2;
    localparam int PX_W      = TOT_W + 3;
    localparam int ACC_W     = PX_W + 19;

    localparam logic signed [18:0] HH_A = 19'((131072 + LINES / 2) / LINES);
    localparam logic signed [ACC_W-1:0] ST_HI  = ACC_W'(ST_MAX);
    localparam logic signed [ACC_W-1:0] ST_LO  = -ST_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMP_HI = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SMP_LO = -SMP_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] M_LIM  = ACC_W'(longint'(MAX_MOD_DELTA) <<< 16);

    // sequencer codes
    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_START  = 5'd2;
    localparam logic [4:0] S_LFO_K  = 5'd3;
    localparam logic [4:0] S_LFO_R  = 5'd4;
    localparam logic [4:0] S_SM1    = 5'd5;
    localparam logic [4:0] S_SM2    = 5'd6;
    localparam logic [4:0] S_MOD    = 5'd7;
    localparam logic [4:0] S_MCL    = 5'd8;
    localparam logic [4:0] S_POS    = 5'd9;
    localparam logic [4:0] S_RED    = 5'd10;
    localparam logic [4:0] S_RDA    = 5'd11;
    localparam logic [4:0] S_RDB    = 5'd12;
    localparam logic [4:0] S_INT1   = 5'd13;
    localparam logic [4:0] S_INT2   = 5'd14;
    localparam logic [4:0] S_HH     = 5'd15;
    localparam logic [4:0] S_MIX    = 5'd16;
    localparam logic [4:0] S_POLE1  = 5'd17;
    localparam logic [4:0] S_POLE2  = 5'd18;
    localparam logic [4:0] S_FB     = 5'd19;
    localparam logic [4:0] S_WR     = 5'd20;
    localparam logic [4:0] S_OSCALE = 5'd21;
    localparam logic [4:0] S_DONE   = 5'd22;

    // filter pole being worked on
    localparam logic [2:0] P_DAMP = 3'd0;
    localparam logic [2:0] P_LF1  = 3'd1;
    localparam logic [2:0] P_LF2  = 3'd2;
    localparam logic [2:0] P_PL1  = 3'd3;
    localparam logic [2:0] P_PL2  = 3'd4;
    localparam logic [2:0] P_PR1  = 3'd5;
    localparam logic [2:0] P_PR2  = 3'd6;

    typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_TABLE_SIZE];

    function automatic sine_tab_t gen_sine();
        sine_tab_t tab;
        for (int k = 0; k < SINE_TABLE_SIZE; k++)
        begin
            tab[k] = sine_at((longint'(k) <<< 24) / SINE_TABLE_SIZE);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = gen_sine();

    function automatic logic [LEN_W-1:0] get_len(input logic [CFG_DATA_W-1:0] cfg,
                                                 input logic [LINE_W-1:0] ln);
        logic [16:0] f;
        f = 17'd0;
        if (32'(ln) < LEN_FIELDS)
        begin
            f = 17'(LEN_FIELD_W'(cfg >> (LEN_FIELD_W * 32'(ln))));
        end
        if (f == 17'd0)
        begin
            f = 17'd1;
        end
        if (f > 17'(MAX_DELAY))
        begin
            f = 17'(MAX_DELAY);
        end
        return LEN_W'(f);
    endfunction

    function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > ST_HI)
        begin
            r = ST_HI;
        end
        else if (v < ST_LO)
        begin
            r = ST_LO;
        end
        return ST_W'(r);
    endfunction

    function automatic logic signed [SW-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > SMP_HI)
        begin
            r = SMP_HI;
        end
        else if (v < SMP_LO)
        begin
            r = SMP_LO;
        end
        return SW'(r);
    endfunction

    // control and configuration
    logic [4:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [LINE_W-1:0]       line_reg, line_next;
    logic [2:0]              pole_sel_reg, pole_sel_next;
    logic [RED_W-1:0]        red_reg, red_next;
    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             fb_gain_reg, fb_gain_next;
    logic [15:0]             damp_coeff_reg, damp_coeff_next;
    logic [15:0]             loop_lp_reg, loop_lp_next;
    logic [15:0]             post_lp_reg, post_lp_next;
    logic [15:0]             mod_depth_reg, mod_depth_next;
    logic [PHASE_W-1:0]      mod_step_reg, mod_step_next;
    logic [15:0]             smooth_coeff_reg, smooth_coeff_next;
    logic [CFG_DATA_W-1:0]   line_cfg_reg, line_cfg_next;

    // per-line and output filter state
    logic [IDX_W-1:0]         wi_reg [LINES], wi_next [LINES];
    logic [PHASE_W-1:0]       phase_reg [LINES], phase_next [LINES];
    logic signed [SINE_W-1:0] smooth_reg [LINES], smooth_next [LINES];
    logic signed [ST_W-1:0]   damp_st_reg [LINES], damp_st_next [LINES];
    logic signed [ST_W-1:0]   lf1_st_reg [LINES], lf1_st_next [LINES];
    logic signed [ST_W-1:0]   lf2_st_reg [LINES], lf2_st_next [LINES];
    logic signed [ST_W-1:0]   post_st_reg [4], post_st_next [4];

    // working registers of one item
    logic [LEN_W-1:0]         len_reg, len_next;
    logic signed [SW-1:0]     rd_reg [LINES], rd_next [LINES];
    logic signed [SW-1:0]     avg_reg, avg_next;
    logic signed [SW-1:0]     avg_term_reg, avg_term_next;
    logic signed [TOT_W-1:0]  total_reg, total_next;
    logic signed [TOT_W-1:0]  sl_reg, sl_next;
    logic signed [TOT_W-1:0]  sr_reg, sr_next;
    logic signed [HH_W-1:0]   hh_reg, hh_next;
    logic [SIN_W-1:0]         sin_k_reg, sin_k_next;
    logic signed [SINE_W-1:0] raw_reg, raw_next;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic signed [M_W-1:0]    m_reg, m_next;
    logic [15:0]              fr_reg, fr_next;
    logic signed [V_W-1:0]    v_reg, v_next;
    logic [IDX_W-1:0]         i1_reg, i1_next;
    logic signed [SW-1:0]     a_reg, a_next;
    logic signed [PX_W-1:0]   pole_x_reg, pole_x_next;
    logic signed [PX_W-1:0]   sr_scaled_reg, sr_scaled_next;
    logic signed [SW-1:0]     out_left_reg, out_left_next;
    logic signed [SW-1:0]     out_right_reg, out_right_next;

    // delay memory
    logic signed [SW-1:0]     mem [MEM_DEPTH];
    logic signed [SW-1:0]     mem_rdata_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [SW-1:0]     mem_wdata;

    // combinational helpers
    logic                     mod_on;
    logic                     last_line;
    logic [ADDR_W-1:0]        line_base;
    logic [15:0]              pole_c;
    logic [16:0]              pole_cinv;
    logic signed [ST_W-1:0]   pole_st;
    logic signed [ACC_W-1:0]  pole_acc;
    logic signed [ST_W-1:0]   pole_y;
    logic [16:0]              smooth_cinv;
    logic signed [ACC_W-1:0]  work_acc;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [V_W-1:0]    red_span;
    logic [IDX_W-1:0]         i0;
    logic [LEN_W-1:0]         idx_inc;
    logic signed [SW:0]       diff;
    logic signed [SW:0]       in_sum;

    assign mod_on    = (mod_depth_reg != 16'd0) && (mod_step_reg != '0);
    assign last_line = (32'(line_reg) == LINES - 1);
    assign line_base = ADDR_W'(line_reg) * ADDR_W'(MAX_DELAY);
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    // coefficient and state of the pole in progress
    always_comb
    begin
        unique case (pole_sel_reg)
            P_DAMP:
            begin
                pole_c  = damp_coeff_reg;
                pole_st = damp_st_reg[line_reg];
            end
            P_LF1:
            begin
                pole_c  = loop_lp_reg;
                pole_st = lf1_st_reg[line_reg];
            end
            P_LF2:
            begin
                pole_c  = loop_lp_reg;
                pole_st = lf2_st_reg[line_reg];
            end
            P_PL1:
            begin
                pole_c  = post_lp_reg;
                pole_st = post_st_reg[0];
            end
            P_PL2:
            begin
                pole_c  = post_lp_reg;
                pole_st = post_st_reg[1];
            end
            P_PR1:
            begin
                pole_c  = post_lp_reg;
                pole_st = post_st_reg[2];
            end
            P_PR2:
            begin
                pole_c  = post_lp_reg;
                pole_st = post_st_reg[3];
            end
            default:
            begin
                pole_c  = post_lp_reg;
                pole_st = post_st_reg[3];
            end
        endcase
        pole_cinv = 17'(17'd65536 - {1'b0, pole_c});
        pole_acc  = prod_reg + ACC_W'($signed({1'b0, pole_cinv})) * ACC_W'(pole_x_reg);
        pole_y    = sat_st(pole_acc >>> 16);
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        line_next         = line_reg;
        pole_sel_next     = pole_sel_reg;
        red_next          = red_reg;
        out_valid_next    = out_valid_reg;
        fb_gain_next      = fb_gain_reg;
        damp_coeff_next   = damp_coeff_reg;
        loop_lp_next      = loop_lp_reg;
        post_lp_next      = post_lp_reg;
        mod_depth_next    = mod_depth_reg;
        mod_step_next     = mod_step_reg;
        smooth_coeff_next = smooth_coeff_reg;
        line_cfg_next     = line_cfg_reg;
        wi_next           = wi_reg;
        phase_next        = phase_reg;
        smooth_next       = smooth_reg;
        damp_st_next      = damp_st_reg;
        lf1_st_next       = lf1_st_reg;
        lf2_st_next       = lf2_st_reg;
        post_st_next      = post_st_reg;
        len_next          = len_reg;
        rd_next           = rd_reg;
        avg_next          = avg_reg;
        avg_term_next     = avg_term_reg;
        total_next        = total_reg;
        sl_next           = sl_reg;
        sr_next           = sr_reg;
        hh_next           = hh_reg;
        sin_k_next        = sin_k_reg;
        raw_next          = raw_reg;
        prod_next         = prod_reg;
        m_next            = m_reg;
        fr_next           = fr_reg;
        v_next            = v_reg;
        i1_next           = i1_reg;
        a_next            = a_reg;
        pole_x_next       = pole_x_reg;
        sr_scaled_next    = sr_scaled_reg;
        out_left_next     = out_left_reg;
        out_right_next    = out_right_reg;
        mem_we            = 1'b0;
        mem_waddr         = clr_addr_reg;
        mem_wdata         = '0;
        mem_raddr         = line_base;
        smooth_cinv       = 17'(17'd65536 - {1'b0, smooth_coeff_reg});
        work_acc          = '0;
        pos_x             = '0;
        red_span          = signed'(V_W'(len_reg) << red_reg);
        i0                = IDX_W'(v_reg);
        idx_inc           = '0;
        diff              = '0;
        in_sum            = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FEEDBACK_GAIN: fb_gain_next      = cfg_data[15:0];
                CFG_DAMPING_COEFF: damp_coeff_next   = cfg_data[15:0];
                CFG_LOOP_LOWPASS:  loop_lp_next      = cfg_data[15:0];
                CFG_POST_LOWPASS:  post_lp_next      = cfg_data[15:0];
                CFG_MOD_DEPTH:     mod_depth_next    = cfg_data[15:0];
                CFG_MOD_STEP:      mod_step_next     = cfg_data[PHASE_W-1:0];
                CFG_SMOOTH_COEFF:  smooth_coeff_next = cfg_data[15:0];
                CFG_LINE_LENGTHS:  line_cfg_next     = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (32'(clr_addr_reg) == MEM_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_sum     = (SW + 1)'(in_left) + (SW + 1)'(in_right);
                    avg_next   = SW'(in_sum >>> 1);
                    line_next  = '0;
                    total_next = '0;
                    sl_next    = '0;
                    sr_next    = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                len_next = get_len(line_cfg_reg, line_reg);
                if (LEN_W'(wi_reg[line_reg]) >= len_next)
                begin
                    wi_next[line_reg] = '0;
                end
                if (mod_on)
                begin
                    phase_next[line_reg] = phase_reg[line_reg] + mod_step_reg;
                    state_next           = S_LFO_K;
                end
                else
                begin
                    m_next     = '0;
                    state_next = S_POS;
                end
            end
            S_LFO_K:
            begin
                sin_k_next = SIN_W'((PH_MUL_W'(phase_reg[line_reg])
                                     * PH_MUL_W'(SINE_TABLE_SIZE)) >> PHASE_W);
                state_next = S_LFO_R;
            end
            S_LFO_R:
            begin
                raw_next   = SINE_TAB[sin_k_reg];
                state_next = S_SM1;
            end
            S_SM1:
            begin
                prod_next  = ACC_W'($signed({1'b0, smooth_coeff_reg}))
                             * ACC_W'(smooth_reg[line_reg]);
                state_next = S_SM2;
            end
            S_SM2:
            begin
                work_acc = prod_reg + ACC_W'($signed({1'b0, smooth_cinv})) * ACC_W'(raw_reg);
                smooth_next[line_reg] = SINE_W'(work_acc >>> 16);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                prod_next  = ACC_W'($signed({1'b0, mod_depth_reg}))
                             * ACC_W'(smooth_reg[line_reg]);
                state_next = S_MCL;
            end
            S_MCL:
            begin
                work_acc = prod_reg >>> 15;
                if (work_acc > M_LIM)
                begin
                    work_acc = M_LIM;
                end
                else if (work_acc < -M_LIM)
                begin
                    work_acc = -M_LIM;
                end
                m_next     = M_W'(work_acc);
                state_next = S_POS;
            end
            S_POS:
            begin
                // position relative to the write point, one full line back, less the offset
                pos_x = ((signed'(POS_W'(wi_reg[line_reg])) - signed'(POS_W'(len_reg))) <<< 16)
                        - POS_W'(m_reg);
                fr_next    = pos_x[15:0];
                v_next     = V_W'(pos_x >>> 16) + (signed'(V_W'(len_reg)) <<< RED_B);
                red_next   = RED_W'(RED_B);
                state_next = S_RED;
            end
            S_RED:
            begin
                // wrap by conditional subtraction of len shifted down one place a step
                if (v_reg >= red_span)
                begin
                    v_next = v_reg - red_span;
                end
                if (red_reg == '0)
                begin
                    state_next = S_RDA;
                end
                else
                begin
                    red_next = red_reg - RED_W'(1);
                end
            end
            S_RDA:
            begin
                mem_raddr = line_base + ADDR_W'(i0);
                idx_inc   = LEN_W'(i0) + LEN_W'(1);
                i1_next   = (idx_inc == len_reg) ? '0 : IDX_W'(idx_inc);
                state_next = S_RDB;
            end
            S_RDB:
            begin
                mem_raddr  = line_base + ADDR_W'(i1_reg);
                a_next     = mem_rdata_reg;
                state_next = S_INT1;
            end
            S_INT1:
            begin
                diff       = (SW + 1)'(mem_rdata_reg) - (SW + 1)'(a_reg);
                prod_next  = ACC_W'(diff) * ACC_W'($signed({1'b0, fr_reg}));
                state_next = S_INT2;
            end
            S_INT2:
            begin
                work_acc = ACC_W'(a_reg) + (prod_reg >>> 16);
                rd_next[line_reg] = SW'(work_acc);
                total_next = total_reg + TOT_W'(work_acc);
                if (line_reg[0] == 1'b0)
                begin
                    sl_next = sl_reg + TOT_W'(work_acc);
                end
                else
                begin
                    sr_next = sr_reg + TOT_W'(work_acc);
                end
                if (last_line)
                begin
                    line_next  = '0;
                    state_next = S_HH;
                end
                else
                begin
                    line_next  = line_reg + LINE_W'(1);
                    state_next = S_START;
                end
            end
            S_HH:
            begin
                hh_next       = HH_W'((ACC_W'(HH_A) * ACC_W'(total_reg)) >>> 16);
                avg_term_next = SW'((ACC_W'(avg_reg) * ACC_W'(IN_SCALE)) >>> 16);
                state_next    = S_MIX;
            end
            S_MIX:
            begin
                len_next      = get_len(line_cfg_reg, line_reg);
                pole_x_next   = PX_W'(hh_reg) - PX_W'(rd_reg[line_reg]);
                pole_sel_next = P_DAMP;
                state_next    = S_POLE1;
            end
            S_POLE1:
            begin
                prod_next  = ACC_W'($signed({1'b0, pole_c})) * ACC_W'(pole_st);
                state_next = S_POLE2;
            end
            S_POLE2:
            begin
                pole_x_next = PX_W'(pole_y);
                state_next  = S_POLE1;
                unique case (pole_sel_reg)
                    P_DAMP:
                    begin
                        damp_st_next[line_reg] = pole_y;
                        pole_sel_next          = P_LF1;
                    end
                    P_LF1:
                    begin
                        lf1_st_next[line_reg] = pole_y;
                        pole_sel_next         = P_LF2;
                    end
                    P_LF2:
                    begin
                        lf2_st_next[line_reg] = pole_y;
                        state_next            = S_FB;
                    end
                    P_PL1:
                    begin
                        post_st_next[0] = pole_y;
                        pole_sel_next   = P_PL2;
                    end
                    P_PL2:
                    begin
                        post_st_next[1] = pole_y;
                        pole_x_next     = sr_scaled_reg;
                        pole_sel_next   = P_PR1;
                    end
                    P_PR1:
                    begin
                        post_st_next[2] = pole_y;
                        pole_sel_next   = P_PR2;
                    end
                    P_PR2:
                    begin
                        post_st_next[3] = pole_y;
                        state_next      = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FB:
            begin
                prod_next  = ACC_W'($signed({1'b0, fb_gain_reg})) * ACC_W'(pole_x_reg);
                state_next = S_WR;
            end
            S_WR:
            begin
                work_acc  = ACC_W'(avg_term_reg) + (prod_reg >>> 16);
                mem_we    = 1'b1;
                mem_waddr = line_base + ADDR_W'(wi_reg[line_reg]);
                mem_wdata = sat_smp(work_acc);
                idx_inc   = LEN_W'(wi_reg[line_reg]) + LEN_W'(1);
                wi_next[line_reg] = (idx_inc >= len_reg) ? '0 : IDX_W'(idx_inc);
                if (last_line)
                begin
                    line_next  = '0;
                    state_next = S_OSCALE;
                end
                else
                begin
                    line_next  = line_reg + LINE_W'(1);
                    state_next = S_MIX;
                end
            end
            S_OSCALE:
            begin
                pole_x_next    = PX_W'((ACC_W'(sl_reg) * ACC_W'(OUT_SCALE)) >>> 16);
                sr_scaled_next = PX_W'((ACC_W'(sr_reg) * ACC_W'(OUT_SCALE)) >>> 16);
                pole_sel_next  = P_PL1;
                state_next     = S_POLE1;
            end
            S_DONE:
            begin
                // hold the result until the previous one has been taken
                if (!out_valid_reg || out_ready)
                begin
                    out_left_next  = sat_smp(ACC_W'(post_st_reg[1]));
                    out_right_next = sat_smp(ACC_W'(post_st_reg[3]));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            line_reg         <= '0;
            pole_sel_reg     <= P_DAMP;
            red_reg          <= '0;
            out_valid_reg    <= 1'b0;
            fb_gain_reg      <= FEEDBACK_GAIN_RST;
            damp_coeff_reg   <= DAMPING_COEFF_RST;
            loop_lp_reg      <= LOOP_LOWPASS_RST;
            post_lp_reg      <= POST_LOWPASS_RST;
            mod_depth_reg    <= MOD_DEPTH_RST;
            mod_step_reg     <= MOD_STEP_RST;
            smooth_coeff_reg <= SMOOTH_COEFF_RST;
            line_cfg_reg     <= LINE_LENGTHS_RST;
            for (int i = 0; i < LINES; i++)
            begin
                wi_reg[i]      <= '0;
                phase_reg[i]   <= PHASE_W'((longint'(i) <<< PHASE_W) / LINES);
                smooth_reg[i]  <= '0;
                damp_st_reg[i] <= '0;
                lf1_st_reg[i]  <= '0;
                lf2_st_reg[i]  <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                post_st_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            line_reg         <= line_next;
            pole_sel_reg     <= pole_sel_next;
            red_reg          <= red_next;
            out_valid_reg    <= out_valid_next;
            fb_gain_reg      <= fb_gain_next;
            damp_coeff_reg   <= damp_coeff_next;
            loop_lp_reg      <= loop_lp_next;
            post_lp_reg      <= post_lp_next;
            mod_depth_reg    <= mod_depth_next;
            mod_step_reg     <= mod_step_next;
            smooth_coeff_reg <= smooth_coeff_next;
            line_cfg_reg     <= line_cfg_next;
            wi_reg           <= wi_next;
            phase_reg        <= phase_next;
            smooth_reg       <= smooth_next;
            damp_st_reg      <= damp_st_next;
            lf1_st_reg       <= lf1_st_next;
            lf2_st_reg       <= lf2_st_next;
            post_st_reg      <= post_st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        rd_reg        <= rd_next;
        avg_reg       <= avg_next;
        avg_term_reg  <= avg_term_next;
        total_reg     <= total_next;
        sl_reg        <= sl_next;
        sr_reg        <= sr_next;
        hh_reg        <= hh_next;
        sin_k_reg     <= sin_k_next;
        raw_reg       <= raw_next;
        prod_reg      <= prod_next;
        m_reg         <= m_next;
        fr_reg        <= fr_next;
        v_reg         <= v_next;
        i1_reg        <= i1_next;
        a_reg         <= a_next;
        pole_x_reg    <= pole_x_next;
        sr_scaled_reg <= sr_scaled_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
    end

    // delay memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

/* src/fdn_checker.sv */
// port level checks of the fdn reverb tank and their bind
`default_nettype none

module fdn_checker #(
    parameter int SAMPLE_WIDTH = fdn_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [fdn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input wire logic [fdn_pkg::CFG_DATA_W-1:0]    cfg_data,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0]    in_left,
    input wire logic signed [SAMPLE_WIDTH-1:0]    in_right,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0]    out_left,
    input wire logic signed [SAMPLE_WIDTH-1:0]    out_right
);
    import fdn_pkg::*;

    logic in_xfer;
    logic cfg_seen;

    assign in_xfer  = in_valid && in_ready;
    assign cfg_seen = cfg_valid && (cfg_index <= CFG_LINE_LENGTHS) && (cfg_data == cfg_data);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
        else $error("output changed while stalled");

    // an offered input pair holds still until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_left) && $stable(in_right))
        else $error("input changed while waiting");

    // after taking an item the block stays busy, with in_ready low, before it takes another
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready ##1 !in_ready)
        else $error("new item taken too soon");

    // a result never appears in the cycle right after an input transfer
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_xfer))
        else $error("result without processing time");

    // configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_seen |-> cfg_ready)
        else $error("configuration transfer stalled");

endmodule

bind fdn_reverb_tank fdn_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fdn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_left   (in_left),
    .in_right  (in_right),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_left  (out_left),
    .out_right (out_right)
);

`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench of the fdn reverb tank with a built-in tank predictor
`timescale 1ns / 1ps

module tb;
    import fdn_pkg::*;

    localparam int NL = 5;
    localparam int DEPTH = 4096;
    localparam int SW = 24;
    localparam longint HH_GAIN = 26214;
    localparam longint MOD_LIM = 64'sd8 << 16;
    localparam longint SAMP_MAX = 64'sd8388607;
    localparam int LIMIT = 3000000;

    typedef struct {
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
    } pair_t;

    typedef struct {
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        bit                   chk;
        logic signed [SW-1:0] el;
        logic signed [SW-1:0] er;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SW-1:0] in_left = '0;
    logic signed [SW-1:0] in_right = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SW-1:0] out_left;
    logic signed [SW-1:0] out_right;

    fdn_reverb_tank dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_left(in_left), .in_right(in_right),
        .out_valid(out_valid), .out_ready(out_ready), .out_left(out_left),
        .out_right(out_right)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tank shadow state
    longint tank_mem [0:NL*DEPTH-1];
    longint wr_pos [NL];
    longint lfo_ph [NL];
    longint lfo_sm [NL];
    longint damp_st [NL];
    longint lp1_st [NL];
    longint lp2_st [NL];
    longint post_st [4];
    longint r_fb, r_damp, r_loop, r_post, r_depth, r_step, r_smooth;
    logic [59:0] r_lengths;

    pair_t tail_q[$];
    int    errors = 0;
    int    n_in = 0;
    int    n_out = 0;
    int    n_cfg = 0;
    int    send_idle = 0;
    int    recv_idle = 0;
    logic  hold_req = 1'b0;
    logic  tab_chk = 1'b0;
    logic signed [SW-1:0] tab_el = '0;
    logic signed [SW-1:0] tab_er = '0;

    function automatic longint sat(input longint x, input longint hi);
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    function automatic longint one_pole(input longint x, input longint st, input longint c);
        return sat((c * st + (65536 - c) * x) >>> 16, 134217727);
    endfunction

    // table entry k, odd polynomial per quadrant in Q22
    function automatic longint sine_entry(input longint k);
        longint ph;
        longint qd;
        longint t;
        longint t2;
        longint p;
        longint v;
        ph = k << 16;
        qd = (ph >> 22) & 3;
        t = ph & 64'h3FFFFF;
        if (qd[0])
            t = 64'h400000 - t;
        t2 = (t * t) >> 22;
        p = 2699019 - ((t2 * 304926) >> 22);
        p = 6588397 - ((t2 * p) >> 22);
        v = ((t * p) >> 22) << 1;
        if (v > SAMP_MAX)
            v = SAMP_MAX;
        return (qd >= 2) ? -v : v;
    endfunction

    function automatic longint len_of(input int i);
        longint n;
        n = longint'(r_lengths[12*i +: 12]);
        return (n == 0) ? 1 : n;
    endfunction

    task automatic shadow_reset();
        for (int i = 0; i < NL*DEPTH; i++)
            tank_mem[i] = 0;
        for (int i = 0; i < NL; i++)
        begin
            wr_pos[i] = 0;
            lfo_ph[i] = (longint'(i) << 24) / NL;
            lfo_sm[i] = 0;
            damp_st[i] = 0;
            lp1_st[i] = 0;
            lp2_st[i] = 0;
        end
        for (int i = 0; i < 4; i++)
            post_st[i] = 0;
        r_fb = 45875; r_damp = 32768; r_loop = 6554; r_post = 6554;
        r_depth = 0; r_step = 0; r_smooth = 62259;
        r_lengths = 60'd493535678103016541;
    endtask

    task automatic tank_step(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                             output pair_t res);
        longint rd [NL];
        longint avg, total, sl, sr, len, span, dly, raw, sm, m, pos, i0, i1, fr, a, b;
        longint mix, d, f1, f2, din;
        bit mod_on;
        avg = (longint'(l) + longint'(r)) >>> 1;
        mod_on = (r_depth != 0) && (r_step != 0);
        total = 0; sl = 0; sr = 0;
        for (int i = 0; i < NL; i++)
        begin
            len = len_of(i);
            span = len << 16;
            dly = span;
            if (wr_pos[i] >= len)
                wr_pos[i] = 0;
            if (mod_on)
            begin
                lfo_ph[i] = (lfo_ph[i] + r_step) & 64'hFFFFFF;
                raw = sine_entry((lfo_ph[i] * 256) >> 24);
                sm = (r_smooth * lfo_sm[i] + (65536 - r_smooth) * raw) >>> 16;
                lfo_sm[i] = sm;
                m = (r_depth * sm) >>> 15;
                if (m > MOD_LIM) m = MOD_LIM;
                if (m < -MOD_LIM) m = -MOD_LIM;
                dly += m;
            end
            pos = (wr_pos[i] << 16) - dly;
            pos = pos % span;
            if (pos < 0)
                pos += span;
            i0 = pos >>> 16;
            fr = pos & 64'hFFFF;
            i1 = (i0 + 1 == len) ? 0 : i0 + 1;
            a = tank_mem[i*DEPTH + i0];
            b = tank_mem[i*DEPTH + i1];
            rd[i] = a + (((b - a) * fr) >>> 16);
            total += rd[i];
            if (i % 2 == 0) sl += rd[i]; else sr += rd[i];
        end
        for (int i = 0; i < NL; i++)
        begin
            len = len_of(i);
            mix = ((HH_GAIN * total) >>> 16) - rd[i];
            d = one_pole(mix, damp_st[i], r_damp);
            f1 = one_pole(d, lp1_st[i], r_loop);
            f2 = one_pole(f1, lp2_st[i], r_loop);
            damp_st[i] = d; lp1_st[i] = f1; lp2_st[i] = f2;
            din = ((avg * 13107) >>> 16) + ((r_fb * f2) >>> 16);
            tank_mem[i*DEPTH + wr_pos[i]] = sat(din, SAMP_MAX);
            wr_pos[i]++;
            if (wr_pos[i] >= len)
                wr_pos[i] = 0;
        end
        sl = (sl * 26214) >>> 16;
        sr = (sr * 26214) >>> 16;
        post_st[0] = one_pole(sl, post_st[0], r_post);
        post_st[1] = one_pole(post_st[0], post_st[1], r_post);
        post_st[2] = one_pole(sr, post_st[2], r_post);
        post_st[3] = one_pole(post_st[2], post_st[3], r_post);
        res.l = SW'(sat(post_st[1], SAMP_MAX));
        res.r = SW'(sat(post_st[3], SAMP_MAX));
    endtask

    initial shadow_reset();

    // accepted transfers on the three channels
    always @(posedge clk)
    begin
        pair_t p;
        pair_t e;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            n_cfg++;
            case (cfg_index)
                CFG_FEEDBACK_GAIN: r_fb = longint'(cfg_data[15:0]);
                CFG_DAMPING_COEFF: r_damp = longint'(cfg_data[15:0]);
                CFG_LOOP_LOWPASS:  r_loop = longint'(cfg_data[15:0]);
                CFG_POST_LOWPASS:  r_post = longint'(cfg_data[15:0]);
                CFG_MOD_DEPTH:     r_depth = longint'(cfg_data[15:0]);
                CFG_MOD_STEP:      r_step = longint'(cfg_data[23:0]);
                CFG_SMOOTH_COEFF:  r_smooth = longint'(cfg_data[15:0]);
                CFG_LINE_LENGTHS:  r_lengths = cfg_data[59:0];
                default: ;
            endcase
        end
        if (rst_n && in_valid && in_ready)
        begin
            tank_step(in_left, in_right, p);
            if (tab_chk)
            begin
                p.l = tab_el;
                p.r = tab_er;
            end
            tail_q.push_back(p);
            n_in++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            n_out++;
            if (tail_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output %0d %0d", out_left, out_right);
            end
            else
            begin
                e = tail_q.pop_front();
                if (e.l !== out_left || e.r !== out_right)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("output %0d: expected %0d %0d, got %0d %0d",
                                 n_out, e.l, e.r, out_left, out_right);
                end
            end
        end
    end

    // receiver, with one long hold-off so the tank backs up
    always @(posedge clk)
    begin
        int hold_cnt;
        bit hold_done;
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_cnt = 900;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        int cyc;
        cyc = 0;
        while (cyc < LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                             input bit chk, input logic signed [SW-1:0] el,
                             input logic signed [SW-1:0] er);
        in_valid <= 1'b1;
        in_left <= l;
        in_right <= r;
        tab_chk <= chk;
        tab_el <= el;
        tab_er <= er;
        do
            @(posedge clk);
        while (!in_ready);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            tab_chk <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        tab_chk <= 1'b0;
        while (tail_q.size() != 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [59:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_regs(input longint fb, input longint dp, input longint lp,
                             input longint pp, input longint md, input longint st,
                             input longint sc, input logic [59:0] ln);
        write_reg(CFG_FEEDBACK_GAIN, 60'(fb));
        write_reg(CFG_DAMPING_COEFF, 60'(dp));
        write_reg(CFG_LOOP_LOWPASS, 60'(lp));
        write_reg(CFG_POST_LOWPASS, 60'(pp));
        write_reg(CFG_MOD_DEPTH, 60'(md));
        write_reg(CFG_MOD_STEP, 60'(st));
        write_reg(CFG_SMOOTH_COEFF, 60'(sc));
        write_reg(CFG_LINE_LENGTHS, ln);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_pairs(input int n);
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        for (int k = 0; k < n; k++)
        begin
            if (n_in >= 400) begin send_idle = 80; recv_idle = 37; end
            if (n_in >= 800) begin send_idle = 0; recv_idle = 0; hold_req <= 1'b1; end
            l = SW'($urandom);
            r = SW'($urandom);
            if ($urandom_range(3) == 0)
            begin
                l = l >>> 10;
                r = r >>> 10;
            end
            send_pair(l, r, 1'b0, '0, '0);
        end
    endtask

    localparam logic signed [SW-1:0] SMX = 24'sh7FFFFF;
    localparam logic signed [SW-1:0] SMN = -24'sh800000;

    row_t dir_rows [] = '{
        '{SMX, SMX, 1'b1, 24'sd0, 24'sd0},
        '{SMN, SMN, 1'b0, 24'sd0, 24'sd0},
        '{SMX, SMN, 1'b0, 24'sd0, 24'sd0},
        '{SMN, SMX, 1'b0, 24'sd0, 24'sd0},
        '{24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{-24'sd1, 24'sd1, 1'b0, 24'sd0, 24'sd0},
        '{24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
        '{-24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
        '{24'sh555555, -24'sh2AAAAB, 1'b0, 24'sd0, 24'sd0},
        '{-24'sh555556, 24'sh2AAAAA, 1'b0, 24'sd0, 24'sd0},
        '{SMX, SMX, 1'b0, 24'sd0, 24'sd0},
        '{SMX, SMX, 1'b0, 24'sd0, 24'sd0}
    };

    initial
    begin
        logic [59:0] ln;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 37;
        recv_idle = 80;
        // first output reads an empty tank
        foreach (dir_rows[k])
            send_pair(dir_rows[k].l, dir_rows[k].r, dir_rows[k].chk,
                      dir_rows[k].el, dir_rows[k].er);
        random_pairs(140);
        drain();
        // short lines with a zero length, strongest loop and modulation
        load_regs(51118, 0, 6554, 62259, 65535, 16777215, 32768,
                  {12'd7, 12'd2, 12'd1, 12'd0, 12'd3});
        for (int k = 0; k < 8; k++)
            send_pair(SMX, SMX, 1'b0, '0, '0);
        random_pairs(140);
        drain();
        load_regs(0, 62259, 62259, 6554, 16'h0180, 24'h012345, 64225,
                  {12'd4095, 12'd100, 12'd37, 12'd5, 12'd64});
        random_pairs(140);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            ln = 60'({$urandom, $urandom});
            if (ph != 5)
                ln = ln & {5{12'h03F}};
            load_regs($urandom_range(51118), $urandom_range(62259),
                      $urandom_range(62259, 6554), $urandom_range(62259, 6554),
                      (ph % 3 == 0) ? 0 : $urandom_range(65535),
                      (ph == 4) ? 0 : $urandom_range(24'hFFFFFF),
                      $urandom_range(64225, 32768), ln);
            random_pairs(130);
            drain();
        end
        $display("covered %0d input pairs, %0d outputs, %0d register writes", n_in, n_out,
                 n_cfg);
        $display("settings from register extremes to random, with and without modulation");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
